/* rtl/core/zba_pkg.sv */
`timescale 1ns / 1ps
package zba_pkg;
    localparam int ZONE_BYTES_DEF = 4096;
    localparam int ZONES_DEF      = 64;
    localparam int MAX_REFS       = 65000;
    localparam int REFS_TOP       = 65535;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_ADDREF = 2'd1,
        OP_DROPREF = 2'd2,
        OP_STATS = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_ROOM  = 3'd1,
        ST_TOO_BIG  = 3'd2,
        ST_OUTSIDE  = 3'd3,
        ST_OVERFREE = 3'd4,
        ST_SATURATED = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_DONE
    } t_state;

    localparam logic [1:0] REG_ZONE_COUNT = 2'd0;
endpackage

/* rtl/core/zoned_bump_allocator_refcount_core.sv */
`timescale 1ns / 1ps
// Zoned bump allocator with per-zone reference counts. Zone heads and counts live in
// one synchronous table memory that a sequencer reads, evaluates and writes back one
// zone per step. Allocate visits zones from the current zone until one has room
// (up to the zones in use), statistics visit all zones in use, reference operations
// visit one, and rejected items and items with no zones in use visit none. After
// reset a clearing pass zeroes the table before the first item is accepted. Results
// sit in an output register, so the next item is accepted while a result waits; a
// finished item holds in its last step until that register is free.
module zoned_bump_allocator_refcount_core
    import zba_pkg::*;
#(
    parameter int ZONE_BYTES = ZONE_BYTES_DEF,
    parameter int ZONES      = ZONES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode[1:0], byte_count[17:2], address[35:18], zeros[39:36]
    input  logic [39:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], alloc_address[20:3], allocated_bytes[39:21],
    // unallocated_bytes[58:40], occupied_zones[65:59], empty_zones[72:66],
    // total_references[94:73], largest_free[107:95], zeros[111:108]
    output logic [111:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int ZW = (ZONES > 1) ? $clog2(ZONES) : 1;
    localparam int HW = $clog2(ZONE_BYTES + 1);
    localparam int CW = $clog2(ZONES + 1);

    logic [6:0] r_zone_count;
    assign pready = 1'b1;
    assign prdata = (paddr == REG_ZONE_COUNT) ? {25'd0, r_zone_count} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_zone_count <= 7'd64;
        else if (psel && penable && pwrite && paddr == REG_ZONE_COUNT)
            r_zone_count <= pwdata[6:0];
    end

    // zones in use
    logic [CW-1:0] w_n;
    always_comb begin
        if (32'(r_zone_count) > ZONES) w_n = CW'(ZONES);
        else w_n = CW'(r_zone_count);
    end

    // table memory: {refs, head}
    logic [HW+15:0] r_mem [ZONES];
    logic [HW+15:0] r_rd;
    logic           w_we;
    logic [ZW-1:0]  w_waddr, w_raddr;
    logic [HW+15:0] w_wdata;
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rd <= r_mem[w_raddr];
    end

    t_state r_state, n_state;
    logic          r_clr;
    logic [CW-1:0] r_clr_cnt;
    logic [ZW-1:0] r_cur, r_z;
    logic [CW-1:0] r_seq;
    logic [1:0]    r_op;
    logic [15:0]   r_bytes;
    logic [2:0]    r_status;
    logic [17:0]   r_aaddr;
    logic [18:0]   r_used, r_room;
    logic [6:0]    r_occ, r_emp;
    logic [21:0]   r_refs;
    logic [12:0]   r_largest;
    logic          r_ovalid;
    logic [111:0]  r_odata;

    logic [HW-1:0] w_head;
    logic [15:0]   w_cnt;
    logic [HW-1:0] w_free;
    logic [ZW-1:0] w_znext;
    logic          w_last;
    logic [31:0]   w_azone;
    logic          w_fit;
    logic          w_accept;
    logic          w_qdone;
    t_status       w_qstatus;
    logic          w_edone;
    logic          w_oload;
    assign w_head = r_rd[HW-1:0];
    assign w_cnt  = r_rd[HW+15:HW];
    assign w_free = HW'(ZONE_BYTES) - w_head;
    assign w_znext = (32'(r_z) + 1 >= 32'(w_n)) ? '0 : ZW'(32'(r_z) + 1);
    assign w_last = (32'(r_seq) + 1 >= 32'(w_n));
    assign w_azone = 32'(s_axis_tdata[35:18]) / ZONE_BYTES;
    assign w_fit = (32'(w_head) + 32'(r_bytes) <= ZONE_BYTES);
    assign w_oload = !r_ovalid || m_axis_tready;

    assign s_axis_tready = !r_clr && r_state == S_IDLE;
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;

    // items that need no table visit finish at once
    always_comb begin
        w_qdone = 1'b0;
        w_qstatus = ST_OK;
        unique case (t_op'(s_axis_tdata[1:0]))
            OP_ALLOC: begin
                if (32'(s_axis_tdata[17:2]) > ZONE_BYTES) begin
                    w_qdone = 1'b1;
                    w_qstatus = ST_TOO_BIG;
                end else if (w_n == '0) begin
                    w_qdone = 1'b1;
                    w_qstatus = ST_NO_ROOM;
                end
            end
            OP_STATS: if (w_n == '0) w_qdone = 1'b1;
            default: if (w_azone >= 32'(w_n)) begin
                w_qdone = 1'b1;
                w_qstatus = ST_OUTSIDE;
            end
        endcase
    end

    always_comb begin
        w_edone = 1'b1;
        unique case (t_op'(r_op))
            OP_ALLOC: w_edone = w_fit || w_last;
            OP_STATS: w_edone = w_last;
            default:  w_edone = 1'b1;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = w_qdone ? S_DONE : S_READ;
            S_READ: n_state = S_EVAL;
            S_EVAL: n_state = w_edone ? S_DONE : S_READ;
            S_DONE: if (w_oload) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_raddr = r_z;
        w_we = 1'b0;
        w_waddr = r_z;
        w_wdata = r_rd;
        if (r_clr) begin
            w_we = 1'b1;
            w_waddr = ZW'(r_clr_cnt);
            w_wdata = '0;
        end else if (r_state == S_EVAL) begin
            unique case (t_op'(r_op))
                OP_ALLOC: if (w_fit) begin
                    w_we = 1'b1;
                    w_wdata = {(w_cnt == 16'(REFS_TOP)) ? w_cnt : w_cnt + 16'd1,
                               HW'(32'(w_head) + 32'(r_bytes))};
                end
                OP_ADDREF: if (32'(w_cnt) < MAX_REFS) begin
                    w_we = 1'b1;
                    w_wdata = {w_cnt + 16'd1, w_head};
                end
                OP_DROPREF: if (w_cnt != 16'd0) begin
                    w_we = 1'b1;
                    w_wdata = {w_cnt - 16'd1, (w_cnt == 16'd1) ? HW'(0) : w_head};
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_clr <= 1'b1;
            r_clr_cnt <= '0;
            r_cur <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_clr) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (32'(r_clr_cnt) == ZONES - 1) r_clr <= 1'b0;
            end
            if (r_state == S_DONE && w_oload) begin
                r_ovalid <= 1'b1;
                r_odata <= {4'd0, r_largest, r_refs, r_emp, r_occ, r_room, r_used,
                            r_aaddr, r_status};
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: if (w_accept) begin
                    r_op <= s_axis_tdata[1:0];
                    r_bytes <= s_axis_tdata[17:2];
                    r_seq <= '0;
                    r_status <= w_qstatus;
                    r_aaddr <= '0;
                    r_used <= '0; r_room <= '0; r_occ <= '0; r_emp <= '0;
                    r_refs <= '0; r_largest <= '0;
                    r_z <= (t_op'(s_axis_tdata[1:0]) == OP_ALLOC)
                           ? ((32'(r_cur) < 32'(w_n)) ? r_cur : '0)
                           : (t_op'(s_axis_tdata[1:0]) == OP_STATS) ? '0
                           : ZW'(w_azone);
                end
                S_READ: ;
                S_EVAL: begin
                    r_seq <= r_seq + 1'b1;
                    unique case (t_op'(r_op))
                        OP_ALLOC: begin
                            if (w_fit) begin
                                r_cur <= r_z;
                                r_aaddr <= 18'(32'(r_z) * ZONE_BYTES + 32'(w_head));
                            end else if (w_last) begin
                                r_status <= ST_NO_ROOM;
                            end else r_z <= w_znext;
                        end
                        OP_ADDREF: begin
                            if (32'(w_cnt) >= MAX_REFS) r_status <= ST_SATURATED;
                        end
                        OP_DROPREF: begin
                            if (w_cnt == 16'd0) r_status <= ST_OVERFREE;
                            else if (w_cnt == 16'd1 && r_z < r_cur) r_cur <= r_z;
                        end
                        OP_STATS: begin
                            r_used <= r_used + 19'(w_head);
                            r_room <= r_room + 19'(w_free);
                            if (w_head != '0) r_occ <= r_occ + 7'd1;
                            else r_emp <= r_emp + 7'd1;
                            r_refs <= r_refs + 22'(w_cnt);
                            if (13'(w_free) > r_largest) r_largest <= 13'(w_free);
                            if (!w_last) r_z <= w_znext;
                        end
                        default: ;
                    endcase
                end
                S_DONE: ;
                default: ;
            endcase
        end
    end
endmodule

/* dv/tb_zoned_bump_allocator_refcount_core.sv */
`timescale 1ns / 1ps
module tb_zoned_bump_allocator_refcount_core;
    import zba_pkg::*;

    localparam int ZBYTES      = 4096;
    localparam int NZONES      = 64;
    localparam int CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        t_status     status;
        logic [17:0] alloc_addr;
        logic [18:0] used_bytes;
        logic [18:0] free_bytes;
        logic [6:0]  occ_zones;
        logic [6:0]  emp_zones;
        logic [21:0] ref_total;
        logic [12:0] largest;
    } t_alloc_result;

    typedef struct packed {
        logic        is_cfg;
        logic [6:0]  cfg_val;
        t_op         op;
        logic [15:0] nbytes;
        logic [17:0] addr;
        logic        typed;
        t_status     status;
        logic [17:0] alloc_addr;
    } t_dir_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [1:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    zoned_bump_allocator_refcount_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // zone table mirror
    logic [12:0] zone_head [NZONES];
    logic [15:0] zone_refs [NZONES];
    int unsigned cur_zone;
    int unsigned zone_cnt;

    t_alloc_result result_q[$];
    int errors;
    int tx_idle;
    int rx_idle;
    int unsigned cycles;

    // result field positions in the output beat
    int fld_lo [8] = '{0, 3, 21, 40, 59, 66, 73, 95};
    int fld_wd [8] = '{3, 18, 19, 19, 7, 7, 22, 13};
    string fld_nm [8] = '{"status", "alloc_address", "allocated_bytes", "unallocated_bytes",
                          "occupied_zones", "empty_zones", "total_references",
                          "largest_free"};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= (rx_idle == 0) ? 1'b1 : ($urandom_range(99) >= rx_idle);
    end

    function automatic int unsigned zones_used();
        return (zone_cnt > NZONES) ? NZONES : zone_cnt;
    endfunction

    function automatic t_alloc_result predict_op(t_op op, int unsigned nbytes,
                                                 int unsigned addr);
        t_alloc_result r;
        int unsigned n, z, old, room;
        int unsigned used, free_sum, refs_sum, big, occ, emp;
        r = '0;
        n = zones_used();
        case (op)
            OP_ALLOC: begin
                if (nbytes > ZBYTES) begin
                    r.status = ST_TOO_BIG;
                end else begin
                    r.status = ST_NO_ROOM;
                    z = (cur_zone < n) ? cur_zone : 0;
                    for (int s = 0; s < n; s++) begin
                        if (zone_head[z] <= ZBYTES - nbytes) begin
                            old = zone_head[z];
                            cur_zone = z;
                            zone_head[z] = 13'(old + nbytes);
                            if (zone_refs[z] < REFS_TOP) zone_refs[z] = zone_refs[z] + 16'd1;
                            r.status = ST_OK;
                            r.alloc_addr = 18'(z * ZBYTES + old);
                            break;
                        end
                        z = (z + 1 >= n) ? 0 : z + 1;
                    end
                end
            end
            OP_ADDREF, OP_DROPREF: begin
                z = addr / ZBYTES;
                if (z >= n) begin
                    r.status = ST_OUTSIDE;
                end else if (op == OP_ADDREF) begin
                    if (zone_refs[z] >= MAX_REFS) begin
                        r.status = ST_SATURATED;
                    end else begin
                        zone_refs[z] = zone_refs[z] + 16'd1;
                        r.status = ST_OK;
                    end
                end else if (zone_refs[z] == 0) begin
                    r.status = ST_OVERFREE;
                end else begin
                    zone_refs[z] = zone_refs[z] - 16'd1;
                    if (zone_refs[z] == 0) begin
                        zone_head[z] = '0;
                        if (z < cur_zone) cur_zone = z;
                    end
                    r.status = ST_OK;
                end
            end
            default: begin
                used = 0; free_sum = 0; refs_sum = 0; big = 0; occ = 0; emp = 0;
                for (int k = 0; k < n; k++) begin
                    room = ZBYTES - zone_head[k];
                    refs_sum += zone_refs[k];
                    if (zone_head[k] != 0) occ++;
                    else emp++;
                    used += zone_head[k];
                    free_sum += room;
                    if (room > big) big = room;
                end
                r.status     = ST_OK;
                r.used_bytes = used[18:0];
                r.free_bytes = free_sum[18:0];
                r.occ_zones  = occ[6:0];
                r.emp_zones  = emp[6:0];
                r.ref_total  = refs_sum[21:0];
                r.largest    = big[12:0];
            end
        endcase
        return r;
    endfunction

    task automatic send_item(t_op op, logic [15:0] nbytes, logic [17:0] addr,
                             logic typed, t_status st, logic [17:0] aaddr);
        t_alloc_result r;
        if (tx_idle != 0 && $urandom_range(99) < tx_idle) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, addr, nbytes, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r = predict_op(op, nbytes, addr);
        if (typed) begin
            r.status     = st;
            r.alloc_addr = aaddr;
        end
        result_q.push_back(r);
    endtask

    // waits for the block to drain, then writes zone_count over the register port
    task automatic write_zone_count(logic [6:0] val);
        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {REG_ZONE_COUNT};
        pwdata  <= {25'b0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        zone_cnt = val;
    endtask

    task automatic send_random();
        t_op op;
        logic [15:0] nb;
        logic [17:0] ad;
        int unsigned n, z, pick;
        n = zones_used();
        pick = $urandom_range(99);
        op = (pick < 45) ? OP_ALLOC : (pick < 60) ? OP_ADDREF : (pick < 90) ? OP_DROPREF
                                                                           : OP_STATS;
        pick = $urandom_range(99);
        if (pick < 55)      nb = 16'($urandom_range(1, 256));
        else if (pick < 80) nb = 16'($urandom_range(0, ZBYTES));
        else if (pick < 90) nb = 16'(ZBYTES);
        else                nb = 16'($urandom_range(0, 65535));
        if (n != 0 && $urandom_range(99) < 85) begin
            // prefer a zone that holds references
            z = $urandom_range(0, n - 1);
            for (int t = 0; t < 4 && zone_refs[z] == 0; t++) z = $urandom_range(0, n - 1);
            ad = 18'(z * ZBYTES + $urandom_range(0, ZBYTES - 1));
        end else begin
            ad = 18'($urandom_range(0, 262143));
        end
        send_item(op, nb, ad, 1'b0, ST_OK, '0);
    endtask

    task automatic random_phase(int items);
        int unsigned sizes [9] = '{1, 2, 3, 4, 6, 8, 16, 64, 0};
        int unsigned sel;
        for (int i = 0; i < items; i++) begin
            if (i % 45 == 0) begin
                sel = sizes[$urandom_range(0, 8)];
                if (sel == 0) sel = $urandom_range(1, 64);
                write_zone_count(sel[6:0]);
            end
            send_random();
        end
    endtask

    t_dir_row dir_rows [26] = '{
        '{1'b0, 7'd0,  OP_STATS,   16'd0,     18'd0,      1'b1, ST_OK,       18'd0},
        '{1'b0, 7'd0,  OP_ALLOC,   16'd0,     18'd0,      1'b1, ST_OK,       18'd0},
        '{1'b0, 7'd0,  OP_ALLOC,   16'd65535, 18'd0,      1'b1, ST_TOO_BIG,  18'd0},
        '{1'b0, 7'd0,  OP_ALLOC,   16'd4097,  18'd0,      1'b1, ST_TOO_BIG,  18'd0},
        '{1'b0, 7'd0,  OP_ALLOC,   16'd4096,  18'd0,      1'b1, ST_OK,       18'd0},
        '{1'b0, 7'd0,  OP_ALLOC,   16'd1,     18'd0,      1'b1, ST_OK,       18'd4096},
        '{1'b0, 7'd0,  OP_ADDREF,  16'd0,     18'd262143, 1'b1, ST_OK,       18'd0},
        '{1'b0, 7'd0,  OP_DROPREF, 16'd0,     18'd262143, 1'b1, ST_OK,       18'd0},
        '{1'b0, 7'd0,  OP_DROPREF, 16'd65535, 18'd262143, 1'b1, ST_OVERFREE, 18'd0},
        '{1'b0, 7'd0,  OP_DROPREF, 16'd0,     18'd0,      1'b1, ST_OK,       18'd0},
        '{1'b0, 7'd0,  OP_DROPREF, 16'd0,     18'd1000,   1'b1, ST_OK,       18'd0},
        '{1'b0, 7'd0,  OP_STATS,   16'd0,     18'd0,      1'b0, ST_OK,       18'd0},
        '{1'b1, 7'd2,  OP_STATS,   16'd0,     18'd0,      1'b0, ST_OK,       18'd0},
        '{1'b0, 7'd0,  OP_ADDREF,  16'd0,     18'd8192,   1'b1, ST_OUTSIDE,  18'd0},
        '{1'b0, 7'd0,  OP_ALLOC,   16'd4096,  18'd0,      1'b1, ST_OK,       18'd0},
        '{1'b0, 7'd0,  OP_ALLOC,   16'd4096,  18'd0,      1'b1, ST_NO_ROOM,  18'd0},
        '{1'b0, 7'd0,  OP_ALLOC,   16'd4095,  18'd0,      1'b1, ST_OK,       18'd4097},
        '{1'b1, 7'd0,  OP_STATS,   16'd0,     18'd0,      1'b0, ST_OK,       18'd0},
        '{1'b0, 7'd0,  OP_ALLOC,   16'd1,     18'd0,      1'b1, ST_NO_ROOM,  18'd0},
        '{1'b0, 7'd0,  OP_ADDREF,  16'd0,     18'd0,      1'b1, ST_OUTSIDE,  18'd0},
        '{1'b0, 7'd0,  OP_STATS,   16'd0,     18'd0,      1'b0, ST_OK,       18'd0},
        '{1'b1, 7'd1,  OP_STATS,   16'd0,     18'd0,      1'b0, ST_OK,       18'd0},
        // current zone is stale here, the scan restarts at zone 0
        '{1'b0, 7'd0,  OP_ALLOC,   16'd0,     18'd0,      1'b1, ST_OK,       18'd4096},
        '{1'b0, 7'd0,  OP_ADDREF,  16'd0,     18'd4095,   1'b0, ST_OK,       18'd0},
        '{1'b0, 7'd0,  OP_STATS,   16'd0,     18'd0,      1'b0, ST_OK,       18'd0},
        '{1'b1, 7'd64, OP_STATS,   16'd0,     18'd0,      1'b0, ST_OK,       18'd0}
    };

    // result checker
    always @(posedge i_clk) begin
        t_alloc_result want;
        logic [111:0] want_vec;
        logic [31:0] e, g;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
                errors++;
            end else begin
                want = result_q.pop_front();
                want_vec = {4'b0, want.largest, want.ref_total, want.emp_zones, want.occ_zones,
                            want.free_bytes, want.used_bytes, want.alloc_addr, want.status};
                for (int f = 0; f < 8; f++) begin
                    e = 32'((want_vec >> fld_lo[f]) & ((112'd1 << fld_wd[f]) - 112'd1));
                    g = 32'((m_axis_tdata >> fld_lo[f]) & ((112'd1 << fld_wd[f]) - 112'd1));
                    if (e !== g) begin
                        $display("%0t: %s mismatch expected %0d actual %0d", $time, fld_nm[f],
                                 e, g);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        errors   = 0;
        cycles   = 0;
        tx_idle  = 27;
        rx_idle  = 48;
        for (int k = 0; k < NZONES; k++) begin
            zone_head[k] = '0;
            zone_refs[k] = '0;
        end
        cur_zone = 0;
        zone_cnt = 64;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) write_zone_count(dir_rows[i].cfg_val);
            else send_item(dir_rows[i].op, dir_rows[i].nbytes, dir_rows[i].addr,
                           dir_rows[i].typed, dir_rows[i].status, dir_rows[i].alloc_addr);
        end

        random_phase(270);
        tx_idle = 48;
        rx_idle = 27;
        random_phase(270);
        tx_idle = 0;
        rx_idle = 0;
        random_phase(260);

        write_zone_count(7'd64);
        send_item(OP_STATS, 16'd0, 18'd0, 1'b0, ST_OK, '0);

        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
